// File: src/ps2_keyboard_to_hid_report_defines.svh
// Assertion macros shared by the keyboard-to-report RTL files.
`ifndef PS2_KEYBOARD_TO_HID_REPORT_DEFINES_SVH
`define PS2_KEYBOARD_TO_HID_REPORT_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define PS2KB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define PS2KB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PS2KB_ASSERT(label, clk, rst, prop, msg)
`define PS2KB_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: src/ps2kb_pkg.sv
// Shared constants, scan-code tables and command type for the keyboard-to-report block.
`default_nettype none
package ps2kb_pkg;

   localparam int KEY_MAP_BITS_DEF = 256;
   localparam int REPORT_SLOTS_DEF = 6;
   localparam int MAX_SLOTS        = 6;
   localparam int FIFO_DEPTH       = 2;
   localparam int RSP_DATA_W       = 64;
   localparam int RSP_ROLL_BIT     = 8 + 8 * MAX_SLOTS;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [7:0] PRE_EXT    = 8'hE0;
   localparam logic [7:0] PRE_PAUSE  = 8'hE1;
   localparam logic [7:0] PRE_BREAK  = 8'hF0;
   localparam logic [7:0] PAUSE_HOLD = 8'h14;

   localparam logic [9:0] CODE_PAUSE    = 10'h277;
   localparam logic [9:0] CODE_APP      = 10'd303;
   localparam logic [9:0] CODE_KP_DIV   = 10'd330;
   localparam logic [9:0] CODE_KP_ENTER = 10'd346;
   localparam logic [9:0] EXT_BASE      = 10'd361;
   localparam int         NORMAL_LEN    = 132;
   localparam int         EXT_LEN       = 21;

   localparam logic [7:0] KEY_PAUSE    = 8'd72;
   localparam logic [7:0] KEY_APP      = 8'd101;
   localparam logic [7:0] KEY_KP_DIV   = 8'd84;
   localparam logic [7:0] KEY_KP_ENTER = 8'd88;

   localparam logic [9:0] TICK_MAX = 10'd1023;

   localparam logic [7:0] NORMAL_CODES [0:NORMAL_LEN-1] = '{
      8'd1,   8'd66, 8'd0,  8'd62, 8'd60, 8'd58, 8'd59, 8'd69,
      8'd0,   8'd67, 8'd65, 8'd63, 8'd61, 8'd43, 8'd53, 8'd0,
      8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd20, 8'd30, 8'd0,
      8'd0,   8'd0,  8'd29, 8'd22, 8'd4,  8'd26, 8'd31, 8'd0,
      8'd0,   8'd6,  8'd27, 8'd7,  8'd8,  8'd33, 8'd32, 8'd0,
      8'd0,   8'd44, 8'd25, 8'd9,  8'd23, 8'd21, 8'd34, 8'd0,
      8'd0,   8'd17, 8'd5,  8'd11, 8'd10, 8'd28, 8'd35, 8'd0,
      8'd0,   8'd0,  8'd16, 8'd13, 8'd24, 8'd36, 8'd37, 8'd0,
      8'd0,   8'd54, 8'd14, 8'd12, 8'd18, 8'd39, 8'd38, 8'd0,
      8'd0,   8'd55, 8'd56, 8'd15, 8'd51, 8'd19, 8'd45, 8'd0,
      8'd0,   8'd0,  8'd52, 8'd0,  8'd47, 8'd46, 8'd0,  8'd0,
      8'd57,  8'd0,  8'd40, 8'd48, 8'd0,  8'd49, 8'd0,  8'd0,
      8'd0,   8'd100,8'd0,  8'd0,  8'd0,  8'd0,  8'd42, 8'd0,
      8'd0,   8'd89, 8'd0,  8'd92, 8'd95, 8'd0,  8'd0,  8'd0,
      8'd98,  8'd99, 8'd90, 8'd93, 8'd94, 8'd96, 8'd41, 8'd83,
      8'd68,  8'd87, 8'd91, 8'd86, 8'd85, 8'd97, 8'd71, 8'd0,
      8'd0,   8'd0,  8'd0,  8'd64
   };

   localparam logic [7:0] EXT_CODES [0:EXT_LEN-1] = '{
      8'd77, 8'd0,  8'd80, 8'd74, 8'd0,  8'd0,  8'd0,  8'd73,
      8'd76, 8'd81, 8'd0,  8'd79, 8'd82, 8'd0,  8'd0,  8'd0,
      8'd0,  8'd78, 8'd0,  8'd70, 8'd75
   };

   // One decoded item handed from the front to the back.
   typedef struct packed {
      logic       tick;
      logic       key_make;
      logic [7:0] key;
      logic [7:0] mods;
   } cmd_type;

   // Map a completed code (pause flag, extended flag, byte) to a USB keycode, 0 if none.
   function automatic logic [7:0] lookup_key(input logic [9:0] code);
      logic [7:0] key;
      logic [9:0] ext_off;
      key     = 8'd0;
      ext_off = code - EXT_BASE;
      if (code < 10'(NORMAL_LEN)) begin
         key = NORMAL_CODES[code[7:0]];
      end else if (code == CODE_PAUSE) begin
         key = KEY_PAUSE;
      end else if (code == CODE_APP) begin
         key = KEY_APP;
      end else if (code == CODE_KP_DIV) begin
         key = KEY_KP_DIV;
      end else if (code == CODE_KP_ENTER) begin
         key = KEY_KP_ENTER;
      end else if (code >= EXT_BASE && code < EXT_BASE + 10'(EXT_LEN)) begin
         key = EXT_CODES[ext_off[4:0]];
      end
      return key;
   endfunction

   // One-hot modifier bit for a completed code, zero when it is no modifier.
   function automatic logic [7:0] modifier_mask(input logic [9:0] code);
      logic [7:0] mask;
      unique case (code)
         10'h014: mask = 8'b0000_0001;
         10'h012: mask = 8'b0000_0010;
         10'h011: mask = 8'b0000_0100;
         10'h11F: mask = 8'b0000_1000;
         10'h114: mask = 8'b0001_0000;
         10'h059: mask = 8'b0010_0000;
         10'h111: mask = 8'b0100_0000;
         10'h127: mask = 8'b1000_0000;
         default: mask = 8'b0000_0000;
      endcase
      return mask;
   endfunction

endpackage
`default_nettype wire

// File: src/ps2kb_front.sv
// Front end: accepts bytes and ticks, tracks prefixes and modifiers, emits commands.
`default_nettype none
module ps2kb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              req_tuser,   // [0] mode
   input  wire logic [7:0]        req_tdata,   // [7:0] scan_byte
   input  wire logic              fifo_full,
   output logic                   cmd_valid,
   output ps2kb_pkg::cmd_type     cmd
);

   logic       e0_ff, e0_in;
   logic       e1_ff, e1_in;
   logic       rel_ff, rel_in;
   logic [7:0] mods_ff, mods_in;
   logic       accept;
   logic [9:0] code;
   logic [7:0] mask;
   logic [7:0] key;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && !fifo_full;
   assign code       = {e1_ff, e0_ff, req_tdata};
   assign mask       = ps2kb_pkg::modifier_mask(code);
   assign key        = ps2kb_pkg::lookup_key(code);

   always_comb begin
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      rel_in       = rel_ff;
      mods_in      = mods_ff;
      cmd_valid    = 1'b0;
      cmd.tick     = 1'b0;
      cmd.key_make = !rel_ff;
      cmd.key      = 8'd0;
      if (accept) begin
         if (req_tuser == ps2kb_pkg::MODE_TICK) begin
            cmd_valid = 1'b1;
            cmd.tick  = 1'b1;
         end else if (!e1_ff && req_tdata == ps2kb_pkg::PRE_EXT) begin
            e0_in = 1'b1;
         end else if (!e1_ff && req_tdata == ps2kb_pkg::PRE_PAUSE) begin
            e1_in = 1'b1;
         end else if (e1_ff && req_tdata == ps2kb_pkg::PAUSE_HOLD) begin
            // drop the middle byte of the pause sequence
         end else if (req_tdata == ps2kb_pkg::PRE_BREAK) begin
            rel_in = 1'b1;
         end else begin
            if (mask != 8'd0) begin
               mods_in = rel_ff ? (mods_ff & ~mask) : (mods_ff | mask);
            end else begin
               cmd.key = key;
            end
            e0_in     = 1'b0;
            e1_in     = 1'b0;
            rel_in    = 1'b0;
            cmd_valid = 1'b1;
         end
      end
      cmd.mods = mods_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff   <= 1'b0;
         e1_ff   <= 1'b0;
         rel_ff  <= 1'b0;
         mods_ff <= 8'd0;
      end else begin
         e0_ff   <= e0_in;
         e1_ff   <= e1_in;
         rel_ff  <= rel_in;
         mods_ff <= mods_in;
      end
   end

endmodule
`default_nettype wire

// File: src/ps2kb_cmd_fifo.sv
// Short command queue between the front end and the report back end.
`default_nettype none
`include "ps2_keyboard_to_hid_report_defines.svh"
module ps2kb_cmd_fifo #(
   parameter int DEPTH = ps2kb_pkg::FIFO_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ps2kb_pkg::cmd_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output ps2kb_pkg::cmd_type      pop_data,
   output logic                    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ps2kb_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PS2KB_ASSERT_NEVER(a_push_full, clock, reset, push && full, "command pushed into full queue")
   `PS2KB_ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "command popped from empty queue")

endmodule
`default_nettype wire

// File: src/ps2kb_back.sv
// Back end: key map, idle timer, eight-bit-per-cycle map scan and report register.
`default_nettype none
`include "ps2_keyboard_to_hid_report_defines.svh"
module ps2kb_back #(
   parameter int KEY_MAP_BITS = ps2kb_pkg::KEY_MAP_BITS_DEF,
   parameter int REPORT_SLOTS = ps2kb_pkg::REPORT_SLOTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [9:0]                       csr_data,
   input  wire logic                             cmd_empty,
   input  wire ps2kb_pkg::cmd_type               cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ps2kb_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int CHUNKS = (KEY_MAP_BITS + 7) / 8;
   localparam int MAP_W  = CHUNKS * 8;
   localparam int CIDX_W = $clog2(CHUNKS);
   localparam int CNT_W  = $clog2(REPORT_SLOTS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [MAP_W-1:0]                    map_ff, map_in;
   logic [7:0]                          mods_ff, mods_in;
   logic [9:0]                          ticks_ff, ticks_in;
   logic [9:0]                          idle_ff;
   logic [CIDX_W-1:0]                   chunk_ff, chunk_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic                                over_ff, over_in;
   logic [7:0]                          slots_ff [REPORT_SLOTS];
   logic [7:0]                          slots_in [REPORT_SLOTS];
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ps2kb_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [9:0]                          tick_next;
   logic [7:0]                          chunk_bits;
   logic                                start;

   assign cmd_pop    = (state_ff == ST_IDLE) && !cmd_empty;
   assign tick_next  = (ticks_ff != ps2kb_pkg::TICK_MAX) ? ticks_ff + 10'd1 : ticks_ff;
   assign chunk_bits = map_ff[{chunk_ff, 3'b000} +: 8];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      map_in       = map_ff;
      mods_in      = mods_ff;
      ticks_in     = ticks_ff;
      chunk_in     = chunk_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      start        = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               mods_in = cmd.mods;
               if (cmd.tick) begin
                  ticks_in = tick_next;
                  start    = (idle_ff != 10'd0) && (tick_next >= idle_ff);
               end else begin
                  // keycode 0 never sets a bit; codes past the map are dropped
                  for (int i = 1; i < KEY_MAP_BITS; i++) begin
                     if (cmd.key == 8'(i)) begin
                        map_in[i] = cmd.key_make;
                     end
                  end
                  start = 1'b1;
               end
            end
            if (start) begin
               ticks_in = 10'd0;
               chunk_in = '0;
               cnt_in   = '0;
               over_in  = 1'b0;
               for (int s = 0; s < REPORT_SLOTS; s++) begin
                  slots_in[s] = 8'd0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            for (int b = 0; b < 8; b++) begin
               if (chunk_bits[b]) begin
                  if (cnt_in < CNT_W'(REPORT_SLOTS)) begin
                     for (int s = 0; s < REPORT_SLOTS; s++) begin
                        if (cnt_in == CNT_W'(s)) begin
                           slots_in[s] = 8'({chunk_ff, 3'(b)});
                        end
                     end
                     cnt_in = cnt_in + 1'b1;
                  end else begin
                     over_in = 1'b1;
                  end
               end
            end
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CIDX_W'(CHUNKS - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // hold the finished report until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in        = '0;
               rsp_data_in[7:0]   = mods_ff;
               for (int s = 0; s < REPORT_SLOTS; s++) begin
                  rsp_data_in[8 + 8 * s +: 8] = over_ff ? 8'd1 : slots_ff[s];
               end
               rsp_data_in[ps2kb_pkg::RSP_ROLL_BIT] = over_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ff       <= '0;
         mods_ff      <= 8'd0;
         ticks_ff     <= 10'd0;
         idle_ff      <= 10'd0;
         chunk_ff     <= '0;
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         mods_ff      <= mods_in;
         ticks_ff     <= ticks_in;
         chunk_ff     <= chunk_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            idle_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slots_ff    <= slots_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PS2KB_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(REPORT_SLOTS), "slot count past report width")
   `PS2KB_ASSERT(a_over_full, clock, reset, over_ff |-> (cnt_ff == CNT_W'(REPORT_SLOTS)), "rollover before slots filled")
   `PS2KB_ASSERT(a_scan_end, clock, reset, (state_ff == ST_SCAN && chunk_ff == CIDX_W'(CHUNKS - 1)) |=> (state_ff == ST_SEND), "scan did not finish on last chunk")
   `PS2KB_ASSERT(a_roll_slot, clock, reset, (rsp_valid_ff && rsp_data_ff[ps2kb_pkg::RSP_ROLL_BIT]) |-> (rsp_data_ff[15:8] == 8'd1), "rollover report without forced slot")

endmodule
`default_nettype wire

// File: src/ps2_keyboard_to_hid_report.sv
// Top level of the PS/2 set-2 keyboard to USB boot-report converter.
//
// Feed received keyboard bytes (req_tuser 0) and one-millisecond ticks (req_tuser 1) on the
// req_ stream; boot reports come out on the rsp_ stream. The back end builds each report by a
// scan of the pressed-key map, which walks the map eight bits per cycle. A two-entry command
// queue sits between the front end and the back end, so bytes keep being accepted while a
// scan runs or a report waits on rsp_tready, until the queue is full. The idle period is
// written through csr_valid/csr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. Zero turns repeat reports off.
`default_nettype none
module ps2_keyboard_to_hid_report #(
   parameter int KEY_MAP_BITS = ps2kb_pkg::KEY_MAP_BITS_DEF,
   parameter int REPORT_SLOTS = ps2kb_pkg::REPORT_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_tuser,  // [0] mode
   input  wire logic [7:0]                    req_tdata,  // [7:0] scan_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] modifier_bits, [15:8] key_slot_0, [23:16] key_slot_1, [31:24] key_slot_2,
   // [39:32] key_slot_3, [47:40] key_slot_4, [55:48] key_slot_5, [56] rollover, rest zero
   output logic [ps2kb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [9:0]                    csr_data    // [9:0] idle_period
);

   logic               cmd_push;
   ps2kb_pkg::cmd_type cmd_in;
   logic               fifo_full;
   logic               fifo_empty;
   logic               cmd_pop;
   ps2kb_pkg::cmd_type cmd_out;

   assign csr_ready = 1'b1;

   ps2kb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .fifo_full  (fifo_full),
      .cmd_valid  (cmd_push),
      .cmd        (cmd_in)
   );

   ps2kb_cmd_fifo #(
      .DEPTH (ps2kb_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (fifo_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (fifo_empty)
   );

   ps2kb_back #(
      .KEY_MAP_BITS (KEY_MAP_BITS),
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd_empty  (fifo_empty),
      .cmd        (cmd_out),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: dv/tb_ps2_keyboard_to_hid_report.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 keyboard to USB boot report converter.
module tb_ps2_keyboard_to_hid_report;

   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int SET2_LEN        = 132;
   localparam int SET2_EXT_LEN    = 21;

   localparam logic [9:0] SC_EXT_FIRST = 10'd361;
   localparam logic [9:0] SC_PAUSE     = 10'h277;
   localparam logic [9:0] SC_APP       = 10'd303;
   localparam logic [9:0] SC_KP_DIV    = 10'd330;
   localparam logic [9:0] SC_KP_ENTER  = 10'd346;
   localparam logic [9:0] TICK_CEILING = 10'd1023;
   localparam logic [7:0] PAUSE_TAIL   = 8'h77;
   localparam logic [7:0] USB_PAUSE    = 8'd72;
   localparam logic [7:0] USB_APP      = 8'd101;
   localparam logic [7:0] USB_KP_DIV   = 8'd84;
   localparam logic [7:0] USB_KP_ENTER = 8'd88;

   // Set-2 byte to USB keycode, 0 where the byte names no key.
   localparam logic [7:0] SET2_KEYS [0:SET2_LEN-1] = '{
      1, 66, 0, 62, 60, 58, 59, 69, 0, 67, 65, 63, 61, 43, 53, 0,
      0, 0, 0, 0, 0, 20, 30, 0, 0, 0, 29, 22, 4, 26, 31, 0,
      0, 6, 27, 7, 8, 33, 32, 0, 0, 44, 25, 9, 23, 21, 34, 0,
      0, 17, 5, 11, 10, 28, 35, 0, 0, 0, 16, 13, 24, 36, 37, 0,
      0, 54, 14, 12, 18, 39, 38, 0, 0, 55, 56, 15, 51, 19, 45, 0,
      0, 0, 52, 0, 47, 46, 0, 0, 57, 0, 40, 48, 0, 49, 0, 0,
      0, 100, 0, 0, 0, 0, 42, 0, 0, 89, 0, 92, 95, 0, 0, 0,
      98, 99, 90, 93, 94, 96, 41, 83, 68, 87, 91, 86, 85, 97, 71, 0,
      0, 0, 0, 64
   };
   // Extended codes from E0 69 upward.
   localparam logic [7:0] SET2_EXT_KEYS [0:SET2_EXT_LEN-1] = '{
      77, 0, 80, 74, 0, 0, 0, 73, 76, 81, 0, 79, 82, 0, 0, 0, 0, 78, 0, 70, 75
   };
   // LCtrl LShift LAlt LGUI RCtrl RShift RAlt RGUI
   localparam logic [9:0] MOD_CODES [0:7] = '{
      10'h014, 10'h012, 10'h011, 10'h11F, 10'h114, 10'h059, 10'h111, 10'h127
   };
   localparam logic [9:0] EXT_SPECIALS [0:6] = '{
      SC_APP, SC_KP_DIV, SC_KP_ENTER, 10'h11F, 10'h114, 10'h111, 10'h127
   };

   typedef struct packed {
      logic            roll;
      logic [5:0][7:0] slot;
      logic [7:0]      mods;
   } boot_report_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic                             req_tuser;   // [0] mode
   logic [7:0]                       req_tdata;   // [7:0] scan_byte
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // [7:0] modifier_bits, [55:8] key_slot_0..5, [56] rollover
   logic [ps2kb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [9:0]                       csr_data;    // [9:0] idle_period

   // Keyboard state as the block should hold it.
   logic [9:0]   idle_period_m = '0;
   logic         ext_pending   = 1'b0;
   logic         pause_pending = 1'b0;
   logic         break_pending = 1'b0;
   logic [7:0]   mods_held     = '0;
   logic [255:0] keys_held     = '0;
   logic [9:0]   tick_count    = '0;

   boot_report_type report_q[$];
   logic [9:0]      held_codes[$];
   int              gap_max        = 14;
   int              stall_max      = 14;
   int              items_sent     = 0;
   int              mismatch_count = 0;
   int              idle_cycles    = 0;

   ps2_keyboard_to_hid_report u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int modifier_index(input logic [9:0] code);
      for (int i = 0; i < 8; i++) begin
         if (MOD_CODES[i] == code) return i;
      end
      return -1;
   endfunction

   function automatic logic [7:0] usb_keycode(input logic [9:0] code);
      if (code < SET2_LEN) return SET2_KEYS[code];
      if (code == SC_PAUSE) return USB_PAUSE;
      if (code == SC_APP) return USB_APP;
      if (code == SC_KP_DIV) return USB_KP_DIV;
      if (code == SC_KP_ENTER) return USB_KP_ENTER;
      if (code >= SC_EXT_FIRST && code < SC_EXT_FIRST + SET2_EXT_LEN)
         return SET2_EXT_KEYS[code - SC_EXT_FIRST];
      return 8'd0;
   endfunction

   function automatic boot_report_type current_boot_report();
      boot_report_type r;
      int              count;
      r     = '0;
      count = 0;
      for (int k = 0; k < 256; k++) begin
         if (keys_held[k]) begin
            if (count < 6) r.slot[count] = 8'(k);
            else r.roll = 1'b1;
            count++;
         end
      end
      if (r.roll) r.slot = {6{8'd1}};
      r.mods = mods_held;
      return r;
   endfunction

   function automatic void queue_report();
      report_q.push_back(current_boot_report());
      tick_count = '0;
   endfunction

   // Advance the keyboard state by one accepted transaction.
   function automatic void predict_item(input logic mode, input logic [7:0] sbyte);
      logic [9:0] code;
      logic [7:0] key;
      int         mi;
      if (mode == ps2kb_pkg::MODE_TICK) begin
         if (tick_count != TICK_CEILING) tick_count = tick_count + 10'd1;
         if (idle_period_m != '0 && tick_count >= idle_period_m) queue_report();
         return;
      end
      if (!pause_pending && sbyte == ps2kb_pkg::PRE_EXT) begin
         ext_pending = 1'b1;
         return;
      end
      if (!pause_pending && sbyte == ps2kb_pkg::PRE_PAUSE) begin
         pause_pending = 1'b1;
         return;
      end
      if (pause_pending && sbyte == ps2kb_pkg::PAUSE_HOLD) return;
      if (sbyte == ps2kb_pkg::PRE_BREAK) begin
         break_pending = 1'b1;
         return;
      end
      code = {pause_pending, ext_pending, sbyte};
      mi   = modifier_index(code);
      if (mi >= 0) begin
         mods_held[mi] = !break_pending;
      end else begin
         key = usb_keycode(code);
         if (key != 8'd0) keys_held[key] = !break_pending;
      end
      ext_pending   = 1'b0;
      pause_pending = 1'b0;
      break_pending = 1'b0;
      queue_report();
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want_v,
                                         input logic [7:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : check_reports
      boot_report_type seen;
      boot_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[56:0];
         if (report_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: report expected none actual %h", $time, rsp_tdata);
         end else begin
            want = report_q.pop_front();
            compare_field("modifier_bits", want.mods, seen.mods);
            for (int s = 0; s < 6; s++)
               compare_field($sformatf("key_slot_%0d", s), want.slot[s], seen.slot[s]);
            compare_field("rollover", 8'(want.roll), 8'(seen.roll));
            compare_field("padding", 8'd0, 8'(rsp_tdata[63:57]));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : drive_rsp_ready
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(stall_max, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Valid stays high after a transaction so back-to-back items need no gap.
   task automatic send_item(input logic mode, input logic [7:0] sbyte);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= sbyte;
      do @(posedge clock); while (!req_tready);
      predict_item(mode, sbyte);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(ps2kb_pkg::MODE_TICK, 8'($urandom_range(255, 0)));
   endtask

   task automatic send_key(input logic [9:0] code, input logic make);
      if (code == SC_PAUSE) begin
         send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_PAUSE);
         if (!make) send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
         send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PAUSE_HOLD);
         if (!make) send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
         send_item(ps2kb_pkg::MODE_BYTE, PAUSE_TAIL);
      end else begin
         if (code[8]) send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);
         if (!make) send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
         send_item(ps2kb_pkg::MODE_BYTE, code[7:0]);
      end
   endtask

   // Drop valid and wait until every report is out and the back end has gone quiet.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_idle_period(input logic [9:0] value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      idle_period_m  = value;
   endtask

   function automatic logic [9:0] pick_known_code();
      int         sel;
      logic [9:0] c;
      sel = $urandom_range(19, 0);
      if (sel < 12) begin
         do c = 10'($urandom_range(SET2_LEN - 1, 0));
         while (SET2_KEYS[c] == 8'd0 && modifier_index(c) < 0);
      end else if (sel < 16) begin
         do c = SC_EXT_FIRST + 10'($urandom_range(SET2_EXT_LEN - 1, 0));
         while (usb_keycode(c) == 8'd0);
      end else if (sel < 19) begin
         c = EXT_SPECIALS[$urandom_range(6, 0)];
      end else begin
         c = SC_PAUSE;
      end
      return c;
   endfunction

   task automatic test_key_codes();
      write_idle_period(10'd0);
      send_key(10'h01C, 1'b1);      // A
      send_key(10'h012, 1'b1);      // left shift
      send_key(10'h114, 1'b1);      // right ctrl
      send_key(10'h127, 1'b1);      // right GUI
      send_key(10'h175, 1'b1);      // up arrow
      send_key(SC_KP_ENTER, 1'b1);
      send_key(SC_KP_DIV, 1'b1);
      send_key(SC_APP, 1'b1);
      send_key(10'h000, 1'b1);      // byte that maps to keycode 1
      send_key(10'h083, 1'b1);      // last entry of the table
      send_item(ps2kb_pkg::MODE_BYTE, 8'h02);  // unknown code still reports
      send_item(ps2kb_pkg::MODE_BYTE, 8'hFF);
      send_key(10'h1FF, 1'b0);
      send_tick();                  // repeats are off
   endtask

   task automatic test_rollover();
      logic [9:0] letters [7] = '{10'h01C, 10'h032, 10'h021, 10'h023, 10'h024, 10'h02B,
                                  10'h034};
      for (int i = 0; i < 7; i++) send_key(letters[i], 1'b1);
      for (int i = 0; i < 7; i++) send_key(letters[i], 1'b0);
      foreach (EXT_SPECIALS[i]) send_key(EXT_SPECIALS[i], 1'b0);
      send_key(10'h012, 1'b0);
      send_key(10'h175, 1'b0);
      send_key(10'h000, 1'b0);
      send_key(10'h083, 1'b0);
   endtask

   task automatic test_pause_and_prefixes();
      send_key(SC_PAUSE, 1'b1);
      send_key(SC_PAUSE, 1'b0);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_PAUSE);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);    // completes an unknown code
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_PAUSE);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_PAUSE);  // completes an unknown code
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);
      send_item(ps2kb_pkg::MODE_BYTE, 8'h75);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
      send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
      send_item(ps2kb_pkg::MODE_BYTE, 8'h75);
   endtask

   task automatic test_idle_repeat();
      write_idle_period(10'd1);
      repeat (3) send_tick();
      write_idle_period(10'd3);
      repeat (2) send_tick();
      send_key(10'h01C, 1'b1);          // key event restarts the count
      repeat (7) send_tick();
      send_key(10'h01C, 1'b0);
      write_idle_period(10'd0);
      repeat (3) send_tick();
   endtask

   task automatic run_random_traffic(input int count);
      int         target;
      int         dice;
      int         idx;
      logic       make;
      logic [9:0] code;
      target = items_sent + count;
      while (items_sent < target) begin
         // Alternate between busy stretches and stretches with random gaps.
         if ($urandom_range(29, 0) == 0) begin
            gap_max   = ($urandom_range(2, 0) == 0) ? 0 : 14;
            stall_max = ($urandom_range(2, 0) == 0) ? 0 : 14;
         end
         dice = $urandom_range(99, 0);
         if (dice < 15) begin
            send_tick();
         end else if (dice < 25) begin
            send_item(ps2kb_pkg::MODE_BYTE, 8'($urandom_range(255, 0)));
         end else if (dice < 30) begin
            case ($urandom_range(2, 0))
               0: send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_EXT);
               1: send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_BREAK);
               default: send_item(ps2kb_pkg::MODE_BYTE, ps2kb_pkg::PRE_PAUSE);
            endcase
         end else begin
            if (held_codes.size() == 0) make = 1'b1;
            else if (held_codes.size() < 4) make = ($urandom_range(3, 0) != 0);
            else if (held_codes.size() > 9) make = ($urandom_range(3, 0) == 0);
            else make = 1'($urandom_range(1, 0));
            if (make) begin
               code = pick_known_code();
               held_codes.push_back(code);
            end else begin
               idx  = $urandom_range(held_codes.size() - 1, 0);
               code = held_codes[idx];
               held_codes.delete(idx);
            end
            send_key(code, make);
         end
      end
   endtask

   task automatic test_random_traffic();
      write_idle_period(10'd0);
      run_random_traffic(130);
      write_idle_period(10'($urandom_range(15, 2)));
      run_random_traffic(130);
      write_idle_period(10'd1);
      run_random_traffic(100);
      write_idle_period(10'($urandom_range(1023, 0)));
      run_random_traffic(130);
      gap_max   = 14;
      stall_max = 14;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ps2kb_pkg::MODE_BYTE;
      req_tdata  <= 8'd0;
      csr_valid  <= 1'b0;
      csr_data   <= 10'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_key_codes();
      test_rollover();
      test_pause_and_prefixes();
      test_idle_repeat();
      test_random_traffic();
      settle_idle();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
